// ----- src/ball_sample_window_averager_defines.svh -----
// ----------------------------------------------------------------------------
// Ball sample window averager: assertion macros
// Shared property wrappers; clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BALL_SAMPLE_WINDOW_AVERAGER_DEFINES_SVH
`define BALL_SAMPLE_WINDOW_AVERAGER_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define BSWA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Invariant that must hold in every cycle outside reset.
`define BSWA_ALWAYS(lbl, expr, msg) \
  `BSWA_CHECK(lbl, 1'b1 |-> (expr), msg)

`endif

// ----- src/bswa_pkg.sv -----
// ----------------------------------------------------------------------------
// Ball sample window averager package
// Sizes, codes and shared types for the averager and its divider.
// ----------------------------------------------------------------------------
package bswa_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int FRACTION_BITS = 16;

  localparam int RAW_W  = 12;
  localparam int TIME_W = 32;
  localparam int OUT_W  = 16;

  localparam int ADDR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int NUM_W   = RAW_W + FRACTION_BITS;
  localparam int SUM_W   = FRACTION_BITS + CNT_W;
  localparam int DIVD_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int DIVS_W  = (RAW_W > CNT_W) ? RAW_W : CNT_W;
  localparam int DSTEP_W = $clog2(DIVD_W + 1);

  localparam int CFG_IDX_W = 2;

  localparam logic [RAW_W-1:0] LEFT_RST   = '0;
  localparam logic [RAW_W-1:0] TOP_RST    = '0;
  localparam logic [RAW_W-1:0] RIGHT_RST  = '1;
  localparam logic [RAW_W-1:0] BOTTOM_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT,
    CFG_TOP,
    CFG_RIGHT,
    CFG_BOTTOM
  } cfg_reg_t;

  typedef enum logic {
    CMD_STORE,
    CMD_QUERY
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_EVAL,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT
  } state_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] x;
    logic [FRACTION_BITS-1:0] y;
    logic [TIME_W-1:0]        stamp;
  } hist_entry_t;

endpackage

// ----- src/bswa_div.sv -----
// ----------------------------------------------------------------------------
// Ball sample window averager: restoring divider
// Unsigned quotient, one bit per cycle; done pulses when quotient is valid.
// ----------------------------------------------------------------------------
module bswa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bswa_pkg::DIVD_W-1:0] dividend,
  input  logic [bswa_pkg::DIVS_W-1:0] divisor,
  output logic                        done,
  output logic [bswa_pkg::DIVD_W-1:0] quotient
);
  import bswa_pkg::*;

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [DSTEP_W-1:0] cnt_r, cnt_nxt;
  logic [DIVD_W-1:0]  quo_r, quo_nxt;
  logic [DIVS_W-1:0]  rem_r, rem_nxt;
  logic [DIVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DIVS_W:0]    trial;
  logic               fits;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = DSTEP_W'(DIVD_W);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (run_r) begin
      // remainder stays below the divisor, so its low bits are enough
      rem_nxt = fits ? DIVS_W'(trial - {1'b0, dvs_r}) : trial[DIVS_W-1:0];
      quo_nxt = {quo_r[DIVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DSTEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- src/ball_sample_window_averager.sv -----
// ----------------------------------------------------------------------------
// Ball sample window averager
// Stores normalised ball positions in a ring history and averages a time
// window of it on request.
// ----------------------------------------------------------------------------
// Channel  Handshake              Payload
// in       start & !busy          in_command, in_ball_x/y, in_sample_time,
//                                 in_window_start, in_window_stop
// out      out_strobe (1 cycle)   out_stored, out_found, out_pos_x, out_pos_y
// cfg      cfg_valid & cfg_ready  cfg_index, cfg_data
//
// One item at a time; busy is high from accept until the result strobe, and stays low for a dropped store.
// Dropped store: result in the cycle after accept. Kept store: two divides
// (x then y) by the shared one-bit-per-cycle divider. Query: walks the
// history newest first through ST_WALK_RD then ST_WALK_EVAL per entry
// (registered memory read), then two divides when anything matched.
// Synchronous reset; the history needs no clearing pass. out has no stall.
// ----------------------------------------------------------------------------
`include "ball_sample_window_averager_defines.svh"

module ball_sample_window_averager (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [bswa_pkg::RAW_W-1:0]  in_ball_x,
  input  logic [bswa_pkg::RAW_W-1:0]  in_ball_y,
  input  logic [bswa_pkg::TIME_W-1:0] in_sample_time,
  input  logic [bswa_pkg::TIME_W-1:0] in_window_start,
  input  logic [bswa_pkg::TIME_W-1:0] in_window_stop,
  output logic                        out_strobe,
  output logic                        out_stored,
  output logic                        out_found,
  output logic [bswa_pkg::OUT_W-1:0]  out_pos_x,
  output logic [bswa_pkg::OUT_W-1:0]  out_pos_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bswa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bswa_pkg::RAW_W-1:0]  cfg_data
);
  import bswa_pkg::*;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;

  logic [RAW_W-1:0] left_r, top_r, right_r, bottom_r;

  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] wstart_r, wstart_nxt;
  logic [TIME_W-1:0] wstop_r, wstop_nxt;
  logic [DIVD_W-1:0] acc_x_r, acc_x_nxt;
  logic [DIVD_W-1:0] acc_y_r, acc_y_nxt;
  logic [RAW_W-1:0]  span_x_r, span_x_nxt;
  logic [RAW_W-1:0]  span_y_r, span_y_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [ADDR_W-1:0] walk_idx_r, walk_idx_nxt;
  logic [CNT_W-1:0]  walk_left_r, walk_left_nxt;
  logic [FRACTION_BITS-1:0] res_x_r, res_x_nxt;
  logic [ADDR_W-1:0] write_slot_r, write_slot_nxt;
  logic [CNT_W-1:0]  fill_count_r, fill_count_nxt;

  logic             out_strobe_r, out_strobe_nxt;
  logic             out_stored_r, out_stored_nxt;
  logic             out_found_r, out_found_nxt;
  logic [OUT_W-1:0] out_pos_x_r, out_pos_x_nxt;
  logic [OUT_W-1:0] out_pos_y_r, out_pos_y_nxt;

  hist_entry_t hist_mem [HISTORY_DEPTH];
  hist_entry_t rd_entry_r;
  hist_entry_t wr_entry;
  logic        mem_we;

  logic              accept;
  logic              on_table;
  logic [RAW_W-1:0]  off_x, off_y;
  logic              phase_y;
  logic              div_start, div_done;
  logic [DIVD_W-1:0] div_dividend, div_quotient, quo_ok;
  logic [DIVS_W-1:0] div_divisor;

  assign accept    = start && !busy;
  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;

  assign on_table = (in_ball_x >= left_r) && (in_ball_x <= right_r) &&
                    (in_ball_y >= top_r) && (in_ball_y <= bottom_r);
  assign off_x  = in_ball_x - left_r;
  assign off_y  = bottom_r - in_ball_y;

  // divider operands follow the phase; a query divides both sums by n
  assign phase_y      = (state_r == ST_Y_GO) || (state_r == ST_Y_WAIT);
  assign div_dividend = phase_y ? acc_y_r : acc_x_r;
  assign div_divisor  = (cmd_r == CMD_QUERY) ? DIVS_W'(n_r) :
                        DIVS_W'(phase_y ? span_y_r : span_x_r);
  assign quo_ok       = (div_divisor == '0) ? '0 : div_quotient;

  bswa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    time_nxt       = time_r;
    wstart_nxt     = wstart_r;
    wstop_nxt      = wstop_r;
    acc_x_nxt      = acc_x_r;
    acc_y_nxt      = acc_y_r;
    span_x_nxt     = span_x_r;
    span_y_nxt     = span_y_r;
    n_nxt          = n_r;
    walk_idx_nxt   = walk_idx_r;
    walk_left_nxt  = walk_left_r;
    res_x_nxt      = res_x_r;
    write_slot_nxt = write_slot_r;
    fill_count_nxt = fill_count_r;
    out_strobe_nxt = 1'b0;
    out_stored_nxt = out_stored_r;
    out_found_nxt  = out_found_r;
    out_pos_x_nxt  = out_pos_x_r;
    out_pos_y_nxt  = out_pos_y_r;
    div_start      = 1'b0;
    mem_we         = 1'b0;
    wr_entry       = '{x: res_x_r, y: FRACTION_BITS'(quo_ok), stamp: time_r};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = cmd_t'(in_command);
          if (cmd_t'(in_command) == CMD_STORE) begin
            if (on_table) begin
              // offset * (2^F - 1) as a shift and subtract
              acc_x_nxt  = DIVD_W'({off_x, {FRACTION_BITS{1'b0}}}) - DIVD_W'(off_x);
              acc_y_nxt  = DIVD_W'({off_y, {FRACTION_BITS{1'b0}}}) - DIVD_W'(off_y);
              span_x_nxt = right_r - left_r;
              span_y_nxt = bottom_r - top_r;
              time_nxt   = in_sample_time;
              state_nxt  = ST_X_GO;
            end else begin
              out_strobe_nxt = 1'b1;
              out_stored_nxt = 1'b0;
              out_found_nxt  = 1'b0;
              out_pos_x_nxt  = '0;
              out_pos_y_nxt  = '0;
            end
          end else begin
            wstart_nxt    = in_window_start;
            wstop_nxt     = in_window_stop;
            acc_x_nxt     = '0;
            acc_y_nxt     = '0;
            n_nxt         = '0;
            walk_idx_nxt  = (write_slot_r == '0) ? ADDR_W'(HISTORY_DEPTH - 1) :
                            write_slot_r - 1'b1;
            walk_left_nxt = fill_count_r;
            state_nxt     = ST_WALK_RD;
          end
        end
      end
      ST_WALK_RD: begin
        if (walk_left_r == '0) begin
          if (n_r == '0) begin
            out_strobe_nxt = 1'b1;
            out_stored_nxt = 1'b0;
            out_found_nxt  = 1'b0;
            out_pos_x_nxt  = '0;
            out_pos_y_nxt  = '0;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_X_GO;
          end
        end else begin
          state_nxt = ST_WALK_EVAL;
        end
      end
      ST_WALK_EVAL: begin
        walk_idx_nxt  = (walk_idx_r == '0) ? ADDR_W'(HISTORY_DEPTH - 1) :
                        walk_idx_r - 1'b1;
        walk_left_nxt = walk_left_r - 1'b1;
        if (rd_entry_r.stamp > wstop_r) begin
          // newer than the window: skip
        end else if (rd_entry_r.stamp < wstart_r) begin
          walk_left_nxt = '0;
        end else begin
          acc_x_nxt = acc_x_r + DIVD_W'(rd_entry_r.x);
          acc_y_nxt = acc_y_r + DIVD_W'(rd_entry_r.y);
          n_nxt     = n_r + 1'b1;
        end
        state_nxt = ST_WALK_RD;
      end
      ST_X_GO: begin
        div_start = 1'b1;
        state_nxt = ST_X_WAIT;
      end
      ST_X_WAIT: begin
        if (div_done) begin
          res_x_nxt = FRACTION_BITS'(quo_ok);
          state_nxt = ST_Y_GO;
        end
      end
      ST_Y_GO: begin
        div_start = 1'b1;
        state_nxt = ST_Y_WAIT;
      end
      ST_Y_WAIT: begin
        if (div_done) begin
          out_strobe_nxt = 1'b1;
          out_pos_x_nxt  = OUT_W'(res_x_r);
          out_pos_y_nxt  = OUT_W'(quo_ok);
          if (cmd_r == CMD_STORE) begin
            mem_we         = 1'b1;
            write_slot_nxt = (write_slot_r == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 :
                             write_slot_r + 1'b1;
            if (fill_count_r < CNT_W'(HISTORY_DEPTH)) begin
              fill_count_nxt = fill_count_r + 1'b1;
            end
            out_stored_nxt = 1'b1;
            out_found_nxt  = 1'b0;
          end else begin
            out_stored_nxt = 1'b0;
            out_found_nxt  = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      write_slot_r <= '0;
      fill_count_r <= '0;
      out_strobe_r <= 1'b0;
      left_r       <= LEFT_RST;
      top_r        <= TOP_RST;
      right_r      <= RIGHT_RST;
      bottom_r     <= BOTTOM_RST;
    end else begin
      state_r      <= state_nxt;
      write_slot_r <= write_slot_nxt;
      fill_count_r <= fill_count_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_LEFT:   left_r   <= cfg_data;
          CFG_TOP:    top_r    <= cfg_data;
          CFG_RIGHT:  right_r  <= cfg_data;
          CFG_BOTTOM: bottom_r <= cfg_data;
          default:    left_r   <= left_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    time_r       <= time_nxt;
    wstart_r     <= wstart_nxt;
    wstop_r      <= wstop_nxt;
    acc_x_r      <= acc_x_nxt;
    acc_y_r      <= acc_y_nxt;
    span_x_r     <= span_x_nxt;
    span_y_r     <= span_y_nxt;
    n_r          <= n_nxt;
    walk_idx_r   <= walk_idx_nxt;
    walk_left_r  <= walk_left_nxt;
    res_x_r      <= res_x_nxt;
    out_stored_r <= out_stored_nxt;
    out_found_r  <= out_found_nxt;
    out_pos_x_r  <= out_pos_x_nxt;
    out_pos_y_r  <= out_pos_y_nxt;
  end

  // history: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[write_slot_r] <= wr_entry;
    end
    rd_entry_r <= hist_mem[walk_idx_r];
  end

  assign out_strobe = out_strobe_r;
  assign out_stored = out_stored_r;
  assign out_found  = out_found_r;
  assign out_pos_x  = out_pos_x_r;
  assign out_pos_y  = out_pos_y_r;

  `BSWA_CHECK(a_strobe_when_idle, out_strobe |-> !busy, "result beat while busy")
  `BSWA_CHECK(a_accept_progress, accept |=> (busy || out_strobe),
              "accepted item neither worked on nor answered")
  `BSWA_ALWAYS(a_flags_exclusive, !(out_strobe && out_stored && out_found),
               "result beat both stored and found")
  `BSWA_ALWAYS(a_fill_bound, fill_count_r <= CNT_W'(HISTORY_DEPTH),
               "fill count beyond history depth")
  `BSWA_CHECK(a_walk_bound, (state_r == ST_WALK_RD) |-> (walk_left_r <= fill_count_r),
              "walk longer than filled history")

endmodule

// ----- test/tb_ball_sample_window_averager.sv -----
// ----------------------------------------------------------------------------
// Ball sample window averager testbench
// Drives store and query commands through the start/busy port and border
// writes through the cfg channel. A scoreboard keeps its own copy of the
// borders and the ring history and predicts every result, which is checked
// field by field against the strobed output.
// ----------------------------------------------------------------------------
module tb_ball_sample_window_averager;
  timeunit 1ns;
  timeprecision 1ps;

  import bswa_pkg::*;

  typedef struct {
    cmd_t              cmd;
    logic [RAW_W-1:0]  bx;
    logic [RAW_W-1:0]  by;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] win_lo;
    logic [TIME_W-1:0] win_hi;
  } ball_cmd_t;

  typedef struct packed {
    logic             stored;
    logic             found;
    logic [OUT_W-1:0] pos_x;
    logic [OUT_W-1:0] pos_y;
  } avg_result_t;

  // Predicts each result from its own copy of the borders and history.
  class window_average_book;
    logic [RAW_W-1:0]         left_edge, top_edge, right_edge, bottom_edge;
    logic [FRACTION_BITS-1:0] hist_x [HISTORY_DEPTH];
    logic [FRACTION_BITS-1:0] hist_y [HISTORY_DEPTH];
    logic [TIME_W-1:0]        hist_stamp [HISTORY_DEPTH];
    int unsigned              next_slot;
    int unsigned              filled;
    avg_result_t              awaited_results [$];
    int                       errors;

    function new();
      left_edge   = LEFT_RST;
      top_edge    = TOP_RST;
      right_edge  = RIGHT_RST;
      bottom_edge = BOTTOM_RST;
      next_slot   = 0;
      filled      = 0;
      errors      = 0;
    endfunction

    function void set_border(cfg_reg_t idx, logic [RAW_W-1:0] value);
      case (idx)
        CFG_LEFT:   left_edge   = value;
        CFG_TOP:    top_edge    = value;
        CFG_RIGHT:  right_edge  = value;
        CFG_BOTTOM: bottom_edge = value;
        default: ;
      endcase
    endfunction

    function logic [63:0] span_fraction(logic [RAW_W-1:0] offset, logic [RAW_W-1:0] span);
      logic [63:0] full;
      full = (64'd1 << FRACTION_BITS) - 64'd1;
      if (span == '0) return 64'd0;
      return ({52'd0, offset} * full) / {52'd0, span};
    endfunction

    function void note_command(ball_cmd_t c);
      avg_result_t r;
      logic [63:0] fx, fy, sum_x, sum_y, q;
      int unsigned hits, slot, k;
      r = '0;
      if (c.cmd == CMD_STORE) begin
        if (c.bx >= left_edge && c.bx <= right_edge &&
            c.by >= top_edge && c.by <= bottom_edge) begin
          // y counts up from the bottom border
          fx = span_fraction(c.bx - left_edge, right_edge - left_edge);
          fy = span_fraction(bottom_edge - c.by, bottom_edge - top_edge);
          hist_x[next_slot]     = fx[FRACTION_BITS-1:0];
          hist_y[next_slot]     = fy[FRACTION_BITS-1:0];
          hist_stamp[next_slot] = c.stamp;
          next_slot = (next_slot + 1) % HISTORY_DEPTH;
          if (filled < HISTORY_DEPTH) filled++;
          r.stored = 1'b1;
          r.pos_x  = fx[OUT_W-1:0];
          r.pos_y  = fy[OUT_W-1:0];
        end
      end else begin
        sum_x = '0;
        sum_y = '0;
        hits  = 0;
        // newest first; storage order, not time order
        for (k = 0; k < filled; k++) begin
          slot = (next_slot + HISTORY_DEPTH - 1 - k) % HISTORY_DEPTH;
          if (hist_stamp[slot] > c.win_hi) continue;
          if (hist_stamp[slot] < c.win_lo) break;
          sum_x += {48'd0, hist_x[slot]};
          sum_y += {48'd0, hist_y[slot]};
          hits++;
        end
        if (hits != 0) begin
          r.found = 1'b1;
          q = sum_x / hits;
          r.pos_x = q[OUT_W-1:0];
          q = sum_y / hits;
          r.pos_y = q[OUT_W-1:0];
        end
      end
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(avg_result_t got);
      avg_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with no command outstanding: stored %0d found %0d x %0d y %0d",
               got.stored, got.found, got.pos_x, got.pos_y);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("out_stored", OUT_W'(want.stored), OUT_W'(got.stored));
      compare_field("out_found", OUT_W'(want.found), OUT_W'(got.found));
      compare_field("out_pos_x", want.pos_x, got.pos_x);
      compare_field("out_pos_y", want.pos_y, got.pos_y);
    endfunction

    function int awaited_count();
      return awaited_results.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  cmd_t              in_command;
  logic [RAW_W-1:0]  in_ball_x;
  logic [RAW_W-1:0]  in_ball_y;
  logic [TIME_W-1:0] in_sample_time;
  logic [TIME_W-1:0] in_window_start;
  logic [TIME_W-1:0] in_window_stop;
  logic              out_strobe;
  logic              out_stored;
  logic              out_found;
  logic [OUT_W-1:0]  out_pos_x;
  logic [OUT_W-1:0]  out_pos_y;
  logic              cfg_valid;
  logic              cfg_ready;
  cfg_reg_t          cfg_index;
  logic [RAW_W-1:0]  cfg_data;

  window_average_book book;
  int                 sender_idle_pct;
  logic [RAW_W-1:0]   lo_x, hi_x, lo_y, hi_y;
  logic [TIME_W-1:0]  now_ms;

  ball_sample_window_averager uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_ball_x       (in_ball_x),
    .in_ball_y       (in_ball_y),
    .in_sample_time  (in_sample_time),
    .in_window_start (in_window_start),
    .in_window_stop  (in_window_stop),
    .out_strobe      (out_strobe),
    .out_stored      (out_stored),
    .out_found       (out_found),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      book.check_result({out_stored, out_found, out_pos_x, out_pos_y});
  end

  function automatic ball_cmd_t store_cmd(logic [RAW_W-1:0] bx, logic [RAW_W-1:0] by,
                                          logic [TIME_W-1:0] stamp);
    ball_cmd_t c;
    c.cmd    = CMD_STORE;
    c.bx     = bx;
    c.by     = by;
    c.stamp  = stamp;
    c.win_lo = $urandom;
    c.win_hi = $urandom;
    return c;
  endfunction

  function automatic ball_cmd_t query_cmd(logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi);
    ball_cmd_t c;
    c.cmd    = CMD_QUERY;
    c.bx     = RAW_W'($urandom_range(0, 4095));
    c.by     = RAW_W'($urandom_range(0, 4095));
    c.stamp  = $urandom;
    c.win_lo = lo;
    c.win_hi = hi;
    return c;
  endfunction

  // Mostly inside the current rectangle, borders hit often.
  function automatic logic [RAW_W-1:0] pick_coord(logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (lo > hi || roll < 20) return RAW_W'($urandom_range(0, 4095));
    if (roll < 28) return lo;
    if (roll < 36) return hi;
    return RAW_W'($urandom_range(lo, hi));
  endfunction

  function automatic ball_cmd_t random_command();
    int unsigned roll;
    logic [TIME_W-1:0] hi;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      roll = $urandom_range(0, 99);
      if (roll < 85) now_ms = now_ms + $urandom_range(0, 40);
      else if (roll < 93) now_ms = now_ms - $urandom_range(1, 100);
      else now_ms = $urandom;
      return store_cmd(pick_coord(lo_x, hi_x), pick_coord(lo_y, hi_y), now_ms);
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      hi = now_ms - $urandom_range(0, 200);
      return query_cmd(hi - $urandom_range(0, 800), hi);
    end
    if (roll < 75) begin
      hi = now_ms + $urandom_range(0, 100);
      return query_cmd(hi - $urandom_range(0, 3000), hi);
    end
    if (roll < 85) return query_cmd('0, '1);
    return query_cmd($urandom, $urandom);
  endfunction

  // Entered at a falling edge; start stays high until the beat is taken.
  task automatic send_command(input ball_cmd_t c);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_command      <= c.cmd;
    in_ball_x       <= c.bx;
    in_ball_y       <= c.by;
    in_sample_time  <= c.stamp;
    in_window_start <= c.win_lo;
    in_window_stop  <= c.win_hi;
    do @(posedge clk); while (busy);
    book.note_command(c);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    while (book.awaited_count() != 0 || busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_borders(input logic [RAW_W-1:0] l, input logic [RAW_W-1:0] t,
                               input logic [RAW_W-1:0] r, input logic [RAW_W-1:0] b);
    logic [RAW_W-1:0] vals [4];
    int i;
    wait_quiet();
    vals = '{l, t, r, b};
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i[CFG_IDX_W-1:0]);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      book.set_border(cfg_reg_t'(i[CFG_IDX_W-1:0]), vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    lo_x = l;
    lo_y = t;
    hi_x = r;
    hi_y = b;
  endtask

  initial begin
    #30_000_000;
    $display("[ball_sample_window_averager] ERROR");
    $finish;
  end

  initial begin
    int phase, kind, i, n;
    logic [RAW_W-1:0] l, t, r, b;
    book = new();
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_command      <= CMD_STORE;
    in_ball_x       <= '0;
    in_ball_y       <= '0;
    in_sample_time  <= '0;
    in_window_start <= '0;
    in_window_stop  <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_LEFT;
    cfg_data        <= '0;
    sender_idle_pct = 0;
    lo_x = LEFT_RST;
    lo_y = TOP_RST;
    hi_x = RIGHT_RST;
    hi_y = BOTTOM_RST;
    now_ms = $urandom;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset borders: empty history, corners, time order quirks
    send_command(query_cmd('0, '1));
    send_command(store_cmd(12'd0, 12'd0, 32'd100));
    send_command(store_cmd(12'd4095, 12'd4095, 32'd200));
    send_command(store_cmd(12'd2048, 12'd1000, 32'd300));
    send_command(query_cmd(32'd100, 32'd300));
    send_command(query_cmd('0, '1));
    send_command(query_cmd(32'd250, 32'd250));
    send_command(query_cmd(32'd0, 32'd50));
    send_command(query_cmd(32'd300, 32'd100));
    send_command(store_cmd(12'd4095, 12'd0, 32'hFFFF_FFFF));
    send_command(store_cmd(12'd1, 12'd4094, 32'd0));
    send_command(query_cmd('0, '1));
    // newest entry older than start ends the walk at once
    send_command(query_cmd(32'd100, '1));
    send_command(query_cmd('1, '1));

    // positions on and just past each border
    write_borders(12'd100, 12'd200, 12'd1000, 12'd900);
    send_command(store_cmd(12'd100, 12'd200, 32'd400));
    send_command(store_cmd(12'd1000, 12'd900, 32'd401));
    send_command(store_cmd(12'd99, 12'd500, 32'd402));
    send_command(store_cmd(12'd1001, 12'd500, 32'd403));
    send_command(store_cmd(12'd500, 12'd199, 32'd404));
    send_command(store_cmd(12'd500, 12'd901, 32'd405));
    send_command(query_cmd(32'd400, 32'd405));

    // zero span on both axes
    write_borders(12'd500, 12'd600, 12'd500, 12'd600);
    send_command(store_cmd(12'd500, 12'd600, 32'd500));
    send_command(store_cmd(12'd501, 12'd600, 32'd501));
    send_command(query_cmd(32'd500, 32'd500));

    // reversed borders drop everything
    write_borders(12'd1000, 12'd900, 12'd100, 12'd200);
    send_command(store_cmd(12'd500, 12'd500, 32'd600));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       sender_idle_pct = 27;
        1:       sender_idle_pct = 63;
        default: sender_idle_pct = 0;
      endcase
      for (kind = 0; kind < 6; kind++) begin
        case (kind)
          0: begin
            l = 12'd0; t = 12'd0; r = 12'd4095; b = 12'd4095;
          end
          1: begin
            l = RAW_W'($urandom_range(0, 4095)); r = RAW_W'($urandom_range(l, 4095));
            t = RAW_W'($urandom_range(0, 4095)); b = RAW_W'($urandom_range(t, 4095));
          end
          2: begin
            // spans of zero to two pixels
            l = RAW_W'($urandom_range(0, 4093)); r = l + RAW_W'($urandom_range(0, 2));
            t = RAW_W'($urandom_range(0, 4093)); b = t + RAW_W'($urandom_range(0, 2));
          end
          3: begin
            l = RAW_W'($urandom_range(1, 4095)); r = RAW_W'($urandom_range(0, l - 1));
            t = RAW_W'($urandom_range(0, 4095)); b = RAW_W'($urandom_range(t, 4095));
          end
          4: begin
            l = RAW_W'($urandom_range(0, 4095)); r = RAW_W'($urandom_range(0, 4095));
            t = RAW_W'($urandom_range(0, 4095)); b = RAW_W'($urandom_range(0, 4095));
          end
          default: begin
            l = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            r = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            t = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            b = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          end
        endcase
        write_borders(l, t, r, b);
        if ($urandom_range(0, 3) == 0) now_ms = $urandom;
        n = (kind == 3) ? 35 : 105;
        for (i = 0; i < n; i++) begin
          // sender holds off until every result is back and the averager is idle
          if (kind == 0 && i == 50) wait_quiet();
          send_command(random_command());
        end
      end
    end

    wait_quiet();
    repeat (200) @(posedge clk);
    if (book.errors == 0 && book.awaited_count() == 0)
      $display("[ball_sample_window_averager] OK");
    else
      $display("[ball_sample_window_averager] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/bswa_pkg.sv
src/bswa_div.sv
src/ball_sample_window_averager.sv
test/tb_ball_sample_window_averager.sv
